FILE: hdl/header_length_frame_receiver_macros.svh
// Assertion shorthands for the frame receiver.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef HEADER_LENGTH_FRAME_RECEIVER_MACROS_SVH
`define HEADER_LENGTH_FRAME_RECEIVER_MACROS_SVH

// Same-cycle implication.
`define HLFR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define HLFR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/hlfr_pkg.sv
package hlfr_pkg;

  localparam int BUF_DEPTH_DEF = 64;

  localparam int OPCODE_W = 2;
  localparam int BYTE_W   = 8;
  localparam int INDEX_W  = 6;

  localparam logic [OPCODE_W-1:0] OP_RECV    = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_RELEASE = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_READ    = 2'd2;

  localparam logic [BYTE_W-1:0] MARK_A    = 8'hFE;
  localparam logic [BYTE_W-1:0] MARK_B    = 8'hEF;
  localparam logic [BYTE_W-1:0] MARK_SUM  = 8'(MARK_A + MARK_B);
  localparam logic [BYTE_W-1:0] SUM_GOOD  = 8'hFF;

endpackage

FILE: hdl/hlfr_item_if.sv
interface hlfr_item_if;
  import hlfr_pkg::*;

  logic                valid;
  logic                ready;
  logic [OPCODE_W-1:0] opcode;
  logic [BYTE_W-1:0]   rx_byte;
  logic [INDEX_W-1:0]  read_index;

  modport source (output valid, opcode, rx_byte, read_index, input ready);
  modport sink   (input valid, opcode, rx_byte, read_index, output ready);
endinterface

FILE: hdl/hlfr_result_if.sv
interface hlfr_result_if;
  import hlfr_pkg::*;

  logic              valid;
  logic              ready;
  logic              frame_ready;
  logic              frame_done;
  logic              checksum_bad;
  logic [BYTE_W-1:0] read_byte;

  modport source (output valid, frame_ready, frame_done, checksum_bad, read_byte,
                  input ready);
  modport sink   (input valid, frame_ready, frame_done, checksum_bad, read_byte,
                  output ready);
endinterface

FILE: hdl/header_length_frame_receiver.sv
// Channel | Dir | Payload                                            | Transaction when
// --------+-----+----------------------------------------------------+-----------------
// item    | in  | opcode, rx_byte, read_index                        | valid & ready
// result  | out | frame_ready, frame_done, checksum_bad, read_byte   | valid & ready
//
// One item per cycle while the result queue has room; each item yields one result,
// registered through the frame store read register and then a three-entry result queue.
// Parser state, the frame store and its valid bits update at the item's transaction.
// rst (synchronous) clears parser state, the valid bits and the queue; the store
// reads as zero until an entry is written, so no clearing pass is needed.
// item.ready drops only when the queue plus the stage in flight hold three results.
module header_length_frame_receiver #(
  parameter int BUF_DEPTH = hlfr_pkg::BUF_DEPTH_DEF
) (
  input logic           clk,
  input logic           rst,
  hlfr_item_if.sink     item,
  hlfr_result_if.source result
);
  import hlfr_pkg::*;

  `include "header_length_frame_receiver_macros.svh"

  // Write position width; range widths fit a depth of up to 256 plus margin.
  localparam int AW = $clog2(BUF_DEPTH);
  localparam logic [8:0]  DEPTH_W = 9'(BUF_DEPTH);
  localparam logic [AW:0] WRAP_AT = (AW+1)'(BUF_DEPTH);
  localparam int Q_DEPTH = 3;

  typedef struct packed {
    logic              frame_ready;
    logic              frame_done;
    logic              checksum_bad;
    logic              rd_en;      // read item with index inside the store
    logic              rd_head;    // index hits the header copy (positions 0..2)
    logic [BYTE_W-1:0] head_byte;
  } stage_t;

  typedef struct packed {
    logic              frame_ready;
    logic              frame_done;
    logic              checksum_bad;
    logic [BYTE_W-1:0] read_byte;
  } result_t;

  // ---------------------------------------------------------------------------
  // Parser state
  // ---------------------------------------------------------------------------
  logic [AW-1:0]     wp, wp_next;
  logic              saw, saw_next;
  logic              in_frame, in_frame_next;
  logic              held, held_next;
  logic [BYTE_W-1:0] sum, sum_next;

  // Positions 0..2 live in flops too: header writes hit 0 and 1 in the same
  // cycle as the regular write, and the length at 2 is checked every byte.
  logic [BYTE_W-1:0] head [3];

  // Frame store: one write port at wp, one registered read port.
  logic [BYTE_W-1:0]    mem [BUF_DEPTH];
  logic [BUF_DEPTH-1:0] vld;
  logic [BYTE_W-1:0]    mem_q;
  logic                 vld_q;

  logic              in_acc, is_recv, take, rel, hdr, complete, good, wrap;
  logic [BYTE_W-1:0] b, sum_add, len_now, head_rd;
  logic [AW-1:0]     wp_base;
  logic [AW:0]       wp_inc;
  logic [8:0]        ridx_w;
  logic [AW-1:0]     raddr;
  logic              ridx_ok;

  // Result path
  stage_t                    s1;
  logic                      s1_v;
  logic [BYTE_W-1:0]         s1_rd;
  result_t                   q [Q_DEPTH];
  logic [1:0]                q_wr, q_rd, q_count;
  logic                      pop;
  logic [2:0]                occ;

  assign occ        = 3'(q_count) + 3'(s1_v);
  assign item.ready = (occ < 3'(Q_DEPTH));
  assign in_acc     = item.valid && item.ready;

  assign b       = item.rx_byte;
  assign is_recv = in_acc && (item.opcode == OP_RECV);
  assign rel     = in_acc && (item.opcode == OP_RELEASE);
  assign take    = is_recv && !held;       // byte stored and parsed
  assign hdr     = take && (b == MARK_B) && saw;
  assign sum_add = sum + b;

  // Length as it stands after this byte's write.
  assign len_now  = (wp == AW'(2)) ? b : head[2];
  assign complete = take && !hdr && in_frame && (9'(wp) > (9'(len_now) + 9'd2));
  assign good     = complete && (sum_add == SUM_GOOD);

  // Completion resets to 0 and the header to 1 before the common advance.
  always_comb begin
    priority if (complete) begin
      wp_base = '0;
    end else if (hdr) begin
      wp_base = AW'(1);
    end else begin
      wp_base = wp;
    end
  end
  assign wp_inc = {1'b0, wp_base} + (AW+1)'(1);
  assign wrap   = (wp_inc == WRAP_AT);

  always_comb begin
    wp_next       = wp;
    saw_next      = saw;
    in_frame_next = in_frame;
    held_next     = held;
    sum_next      = sum;
    if (take) begin
      saw_next = (b == MARK_A) && !complete;
      sum_next = hdr ? MARK_SUM : sum_add;
      if (hdr) begin
        in_frame_next = 1'b1;
      end else if (complete) begin
        in_frame_next = 1'b0;
      end
      if (good) begin
        held_next = 1'b1;
      end
    end
    if (rel) begin
      held_next = 1'b0;
    end
    // Position advances even while a frame is held; a wrap abandons the frame.
    if (is_recv) begin
      wp_next = wrap ? '0 : wp_inc[AW-1:0];
      if (wrap) begin
        in_frame_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp       <= '0;
      saw      <= 1'b0;
      in_frame <= 1'b0;
      held     <= 1'b0;
      sum      <= '0;
    end else begin
      wp       <= wp_next;
      saw      <= saw_next;
      in_frame <= in_frame_next;
      held     <= held_next;
      sum      <= sum_next;
    end
  end

  // Header copy; later assignments win, so the markers override a wp write.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < 3; k++) begin
        head[k] <= '0;
      end
    end else if (take) begin
      for (int k = 0; k < 3; k++) begin
        if (wp == AW'(k)) begin
          head[k] <= b;
        end
      end
      if (hdr) begin
        head[0] <= MARK_A;
        head[1] <= MARK_B;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Frame store
  // ---------------------------------------------------------------------------
  assign ridx_w  = 9'(item.read_index);
  assign ridx_ok = (ridx_w < DEPTH_W);
  assign raddr   = ridx_w[AW-1:0];

  always_ff @(posedge clk) begin
    if (take) begin
      mem[wp] <= b;
    end
    if (in_acc) begin
      mem_q <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld   <= '0;
      vld_q <= 1'b0;
    end else begin
      if (take) begin
        vld[wp] <= 1'b1;
      end
      if (in_acc) begin
        vld_q <= vld[raddr];
      end
    end
  end

  always_comb begin
    unique case (item.read_index[1:0])
      2'd0:    head_rd = head[0];
      2'd1:    head_rd = head[1];
      2'd2:    head_rd = head[2];
      default: head_rd = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Stage 1: flags plus read select, aligned with the store read register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else begin
      s1_v <= in_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1.frame_ready  <= held_next;
      s1.frame_done   <= good;
      s1.checksum_bad <= complete && !good;
      s1.rd_en        <= (item.opcode == OP_READ) && ridx_ok;
      s1.rd_head      <= (ridx_w < 9'd3);
      s1.head_byte    <= head_rd;
    end
  end

  // Unwritten store entries read as zero.
  always_comb begin
    priority if (!s1.rd_en) begin
      s1_rd = '0;
    end else if (s1.rd_head) begin
      s1_rd = s1.head_byte;
    end else begin
      s1_rd = vld_q ? mem_q : '0;
    end
  end

  // ---------------------------------------------------------------------------
  // Result queue: decouples the result side from the item side
  // ---------------------------------------------------------------------------
  assign pop = result.valid && result.ready;

  always_ff @(posedge clk) begin
    if (s1_v) begin
      q[q_wr] <= '{frame_ready:  s1.frame_ready,
                   frame_done:   s1.frame_done,
                   checksum_bad: s1.checksum_bad,
                   read_byte:    s1_rd};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q_wr    <= '0;
      q_rd    <= '0;
      q_count <= '0;
    end else begin
      if (s1_v) begin
        q_wr <= (q_wr == 2'(Q_DEPTH - 1)) ? '0 : q_wr + 2'd1;
      end
      if (pop) begin
        q_rd <= (q_rd == 2'(Q_DEPTH - 1)) ? '0 : q_rd + 2'd1;
      end
      q_count <= 2'(3'(q_count) + 3'(s1_v) - 3'(pop));
    end
  end

  assign result.valid        = (q_count != 2'd0);
  assign result.frame_ready  = q[q_rd].frame_ready;
  assign result.frame_done   = q[q_rd].frame_done;
  assign result.checksum_bad = q[q_rd].checksum_bad;
  assign result.read_byte    = q[q_rd].read_byte;

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  `HLFR_ASSERT_NOW(a_no_overflow, s1_v, q_count != 2'(Q_DEPTH) || pop, "result queue overflow")
  `HLFR_ASSERT_NOW(a_flags_excl, s1_v, !(s1.frame_done && s1.checksum_bad), "good and bad at once")
  `HLFR_ASSERT_NOW(a_ready_tracks, s1_v, s1.frame_ready == held, "frame_ready out of step with hold")
  `HLFR_ASSERT_NEXT(a_release, rel, !held, "release did not drop the hold")
  `HLFR_ASSERT_NOW(a_wp_range, 1'b1, 9'(wp) < DEPTH_W, "write position past the store")

endmodule

FILE: tb/hlfr_frame_checker.sv
module hlfr_frame_checker #(
  parameter int DEPTH = hlfr_pkg::BUF_DEPTH_DEF
) (
  input  logic   clk,
  input  logic   rst,
  hlfr_item_if   item,
  hlfr_result_if result,
  output int     errors,
  output int     pending,
  output int     frames_good,
  output int     frames_bad
);
  import hlfr_pkg::*;

  typedef struct packed {
    logic              frame_ready;
    logic              frame_done;
    logic              checksum_bad;
    logic [BYTE_W-1:0] read_byte;
  } frame_result_t;

  // shadow parser state
  logic [BYTE_W-1:0] frame_bytes [DEPTH];
  int                wr_pos;
  bit                seen_fe;
  bit                in_frame;
  bit                held;
  logic [BYTE_W-1:0] run_sum;

  frame_result_t expected_results[$];
  int err_cnt  = 0;
  int good_cnt = 0;
  int bad_cnt  = 0;
  int pend_cnt = 0;

  assign errors      = err_cnt;
  assign pending     = pend_cnt;
  assign frames_good = good_cnt;
  assign frames_bad  = bad_cnt;

  task automatic clear_parser();
    foreach (frame_bytes[i]) frame_bytes[i] = '0;
    wr_pos   = 0;
    seen_fe  = 0;
    in_frame = 0;
    held     = 0;
    run_sum  = '0;
  endtask

  task automatic step_parser(input logic [OPCODE_W-1:0] op, input logic [BYTE_W-1:0] b,
                             input logic [INDEX_W-1:0] idx, output frame_result_t r);
    bit header;
    bit completed;
    r         = '0;
    header    = 0;
    completed = 0;
    case (op)
      OP_RECV: begin
        if (!held) begin
          if (wr_pos < DEPTH) frame_bytes[wr_pos] = b;
          if (b == MARK_A) begin
            seen_fe = 1;
            run_sum = run_sum + b;
          end else if (b == MARK_B && seen_fe) begin
            // header pair restarts the frame at position 0
            seen_fe        = 0;
            in_frame       = 1;
            frame_bytes[0] = MARK_A;
            frame_bytes[1] = MARK_B;
            wr_pos         = 1;
            run_sum        = MARK_SUM;
            header         = 1;
          end else begin
            seen_fe = 0;
            run_sum = run_sum + b;
          end
          if (!header && in_frame && wr_pos > int'(frame_bytes[2]) + 2) begin
            completed = 1;
            seen_fe   = 0;
            in_frame  = 0;
            wr_pos    = 0;
            if (run_sum == SUM_GOOD) begin
              held         = 1;
              r.frame_done = 1;
              good_cnt++;
            end else begin
              r.checksum_bad = 1;
              bad_cnt++;
            end
          end
        end
        // position advances even while a frame is held
        wr_pos++;
        if (wr_pos >= DEPTH) begin
          wr_pos = 0;
          if (!completed) in_frame = 0;
        end
      end
      OP_RELEASE: held = 0;
      OP_READ: if (int'(idx) < DEPTH) r.read_byte = frame_bytes[idx];
      default: ;
    endcase
    r.frame_ready = held;
  endtask

  task automatic check_field(input string name, input logic [BYTE_W-1:0] exp_v,
                             input logic [BYTE_W-1:0] act_v);
    if (act_v !== exp_v) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
      err_cnt++;
    end
  endtask

  always @(posedge clk) begin
    frame_result_t exp_r;
    frame_result_t new_r;
    if (rst) begin
      clear_parser();
      expected_results.delete();
    end else begin
      // result side first: it always belongs to an older transaction
      if (result.valid && result.ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: result with nothing expected, actual ready=%0b done=%0b bad=%0b byte=%0h",
                   $time, result.frame_ready, result.frame_done, result.checksum_bad,
                   result.read_byte);
          err_cnt++;
        end else begin
          exp_r = expected_results.pop_front();
          check_field("frame_ready", BYTE_W'(exp_r.frame_ready), BYTE_W'(result.frame_ready));
          check_field("frame_done", BYTE_W'(exp_r.frame_done), BYTE_W'(result.frame_done));
          check_field("checksum_bad", BYTE_W'(exp_r.checksum_bad),
                      BYTE_W'(result.checksum_bad));
          check_field("read_byte", exp_r.read_byte, result.read_byte);
        end
      end
      if (item.valid && item.ready) begin
        step_parser(item.opcode, item.rx_byte, item.read_index, new_r);
        expected_results.push_back(new_r);
      end
    end
    pend_cnt = expected_results.size();
  end

endmodule

FILE: tb/tb_top.sv
module tb_top;
  import hlfr_pkg::*;

  // opcode value the block must treat as a no-op
  localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;
  // length of the forced receiver hold-off, in cycles
  localparam int HOLD_CYCLES = 60;
  // settle time after the last result: two-stage pipe plus margin
  localparam int DRAIN_CYCLES = 8;

  logic clk;
  logic rst;

  hlfr_item_if   item_ch();
  hlfr_result_if result_ch();

  int  errors;
  int  pending;
  int  frames_good;
  int  frames_bad;
  int  items_sent   = 0;
  int  tx_idle_pct  = 0;
  int  rx_stall_pct = 0;
  // hold-offs requested by the stimulus; the receiver counts the ones it served
  int  hold_reqs    = 0;

  header_length_frame_receiver u_top (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (result_ch)
  );

  // Passive side: predicts every item transaction and scores every result transaction.
  hlfr_frame_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .item        (item_ch),
    .result      (result_ch),
    .errors      (errors),
    .pending     (pending),
    .frames_good (frames_good),
    .frames_bad  (frames_bad)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Hard stop; far above the slowest legal run.
  initial begin
    #2000000;
    $display("%0t: timeout with %0d results outstanding", $time, pending);
    $display("== FAIL ==");
    $finish;
  end

  // Receiver side. Random stalls at the current phase rate; when the stimulus
  // asks for a hold-off, ready stays low for the length of the hold-off so the result queue
  // fills up and the block has to drop item ready.
  initial begin
    int holds_done;
    holds_done = 0;
    result_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_reqs != holds_done) begin
        result_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        holds_done++;
      end else begin
        result_ch.ready <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  // One item transaction. Idle gaps are inserted before the item at the phase
  // rate; valid is only ever assigned once per time step, so back-to-back
  // items keep valid high without a glitch.
  task automatic put_item(input logic [OPCODE_W-1:0] op, input logic [BYTE_W-1:0] b,
                          input logic [INDEX_W-1:0] idx);
    while ($urandom_range(99) < tx_idle_pct) begin
      item_ch.valid <= 1'b0;
      @(posedge clk);
    end
    item_ch.valid      <= 1'b1;
    item_ch.opcode     <= op;
    item_ch.rx_byte    <= b;
    item_ch.read_index <= idx;
    do @(posedge clk); while (!item_ch.ready);
    items_sent++;
  endtask

  // Unused payload fields carry random values so every bit toggles.
  task automatic send_byte(input logic [BYTE_W-1:0] b);
    put_item(OP_RECV, b, INDEX_W'($urandom_range(63)));
  endtask

  task automatic read_at(input logic [INDEX_W-1:0] idx);
    put_item(OP_READ, BYTE_W'($urandom_range(255)), idx);
  endtask

  task automatic release_frame();
    put_item(OP_RELEASE, BYTE_W'($urandom_range(255)), INDEX_W'($urandom_range(63)));
  endtask

  // FE EF L, L random payload bytes, then the checksum that closes the 8-bit sum
  // to SUM_GOOD (or a corrupted one). cut >= 0 truncates after that many bytes.
  task automatic send_frame(input int len, input bit good_sum, input int cut);
    logic [BYTE_W-1:0] frame_q[$];
    logic [BYTE_W-1:0] sum;
    logic [BYTE_W-1:0] pay;
    int                n;
    frame_q = {MARK_A, MARK_B, BYTE_W'(len)};
    sum     = MARK_SUM + BYTE_W'(len);
    for (int i = 0; i < len; i++) begin
      pay = BYTE_W'($urandom_range(255));
      frame_q.push_back(pay);
      sum = sum + pay;
    end
    pay = SUM_GOOD - sum;
    if (!good_sum) pay = pay + BYTE_W'($urandom_range(1, 255));
    frame_q.push_back(pay);
    n = (cut >= 0 && cut < frame_q.size()) ? cut : frame_q.size();
    for (int i = 0; i < n; i++) send_byte(frame_q[i]);
  endtask

  // Random traffic, mostly frames. A frame is usually
  // followed by up to two reads and a release so the parser does not sit in the
  // held state ignoring everything.
  task automatic run_phase(input int tx_pct, input int rx_pct, input int count,
                           input bit with_hold);
    int target;
    int pick;
    int len;
    int cut;
    tx_idle_pct  = tx_pct;
    rx_stall_pct = rx_pct;
    target       = items_sent + count;
    if (with_hold) hold_reqs <= hold_reqs + 1;
    while (items_sent < target) begin
      pick = $urandom_range(99);
      if (pick < 60) begin
        // occasional long frame: near or past the store depth; one that does not fit wraps and is dropped
        len = ($urandom_range(39) == 0) ? $urandom_range(56, 72) : $urandom_range(0, 8);
        cut = ($urandom_range(9) == 0) ? $urandom_range(0, len + 3) : -1;
        send_frame(len, $urandom_range(3) != 0, cut);
        if ($urandom_range(9) < 7) begin
          repeat ($urandom_range(2)) read_at(INDEX_W'($urandom_range(63)));
          release_frame();
        end
      end else if (pick < 72) begin
        read_at(INDEX_W'($urandom_range(63)));
      end else if (pick < 80) begin
        release_frame();
      end else if (pick < 84) begin
        put_item(OP_UNUSED, BYTE_W'($urandom_range(255)), INDEX_W'($urandom_range(63)));
      end else if (pick < 94) begin
        send_byte(BYTE_W'($urandom_range(255)));
      end else begin
        // stray markers: lone FE, lone EF, or FE runs
        send_byte($urandom_range(1) ? MARK_A : MARK_B);
      end
    end
  endtask

  initial begin
    rst                <= 1'b1;
    item_ch.valid      <= 1'b0;
    item_ch.opcode     <= OP_RECV;
    item_ch.rx_byte    <= '0;
    item_ch.read_index <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed part, no idling.
    read_at(INDEX_W'(0));                 // store reads as zero after reset
    read_at(INDEX_W'(63));                // last store entry
    put_item(OP_UNUSED, 8'hFF, 6'h3F);    // unused opcode, all-ones payload
    put_item(OP_RELEASE, 8'h00, 6'h00);   // release with nothing held
    send_frame(0, 1'b1, -1);              // shortest good frame -> held
    send_byte(MARK_A);                    // ignored while held, position still moves
    read_at(INDEX_W'(3));                 // checksum byte of the held frame
    put_item(OP_UNUSED, 8'h00, 6'h00);    // frame_ready must still show held
    release_frame();
    send_frame(0, 1'b0, -1);              // checksum failure
    send_byte(MARK_A);                    // FE FE EF: header pair after a stray FE
    send_frame(1, 1'b1, -1);
    release_frame();
    send_frame(3, 1'b1, 4);               // truncated frame ...
    send_frame(0, 1'b1, -1);              // ... restarted by a new header
    release_frame();
    read_at(INDEX_W'(2));                 // length byte

    // Random part across the idle/stall mixes; hold-offs fill the pipe.
    run_phase(0, 0, 400, 1'b1);
    run_phase(48, 0, 400, 1'b0);
    run_phase(0, 48, 400, 1'b0);
    run_phase(14, 14, 400, 1'b1);

    item_ch.valid <= 1'b0;
    // Checker counters move on the rising edge; read them on the falling edge.
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Run covered %0d item transactions over four idle/stall mixes with hold-offs,",
             items_sent);
    $display("including %0d good frames and %0d checksum failures.", frames_good, frames_bad);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
